// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the calendar field adjuster RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property, disabled during reset.
`define CFA_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define CFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/cfa_pkg.sv =====
// Package for the calendar field adjuster: payload types, command and
// field codes, and the month-length / leap-year helpers. No dependencies.
package cfa_pkg;

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_INC   = 2'd1;
  localparam logic [1:0] CMD_DEC   = 2'd2;
  localparam logic [1:0] CMD_WRITE = 2'd3;

  localparam logic [2:0] FLD_YEAR    = 3'd0;
  localparam logic [2:0] FLD_MONTH   = 3'd1;
  localparam logic [2:0] FLD_DAY     = 3'd2;
  localparam logic [2:0] FLD_WEEKDAY = 3'd3;
  localparam logic [2:0] FLD_HOUR    = 3'd4;
  localparam logic [2:0] FLD_MINUTE  = 3'd5;
  localparam logic [2:0] FLD_SECOND  = 3'd6;
  localparam logic [2:0] FLD_NONE    = 3'd7;

  localparam logic [11:0] YEAR_MAX    = 12'd4095;
  localparam logic [11:0] MONTH_MAX   = 12'd11;
  localparam logic [11:0] WEEKDAY_MAX = 12'd6;
  localparam logic [11:0] HOUR_MAX    = 12'd23;
  localparam logic [11:0] MINUTE_MAX  = 12'd59;
  localparam logic [11:0] SECOND_MAX  = 12'd59;

  // Divisibility by 25: multiply by the inverse of 25 mod 2^12 and compare.
  localparam logic [11:0] INV25       = 12'd3113;
  localparam logic [11:0] DIV25_LIMIT = 12'd163;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [2:0]  field_select;
    logic [5:0]  new_second;
    logic [5:0]  new_minute;
    logic [4:0]  new_hour;
    logic [4:0]  new_day_of_month;
    logic [2:0]  new_weekday;
    logic [8:0]  new_day_of_year;
    logic [3:0]  new_month;
    logic [11:0] new_year;
  } cfa_in_t;

  typedef struct packed {
    logic [5:0]  second_out;
    logic [5:0]  minute_out;
    logic [4:0]  hour_out;
    logic [4:0]  day_of_month_out;
    logic [2:0]  weekday_out;
    logic [8:0]  day_of_year_out;
    logic [3:0]  month_out;
    logic [11:0] year_out;
  } cfa_out_t;

  typedef struct packed {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day_of_month;
    logic [2:0]  weekday;
    logic [8:0]  day_of_year;
    logic [3:0]  month;
    logic [11:0] year;
  } cfa_cal_t;

  // Gregorian rule: div by 4 and not by 100, or div by 400.
  // 100 = 4*25 and 400 = 16*25, so only a test by 25 is needed.
  function automatic logic is_leap(input logic [11:0] y);
    logic [11:0] prod;
    logic        div25;
    prod  = y * INV25;
    div25 = (prod <= DIV25_LIMIT);
    return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic [11:0] y);
    logic [4:0] d;
    case (m)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: d = 5'd31;
      4'd3, 4'd5, 4'd8, 4'd10:                    d = 5'd30;
      4'd1:    d = is_leap(y) ? 5'd29 : 5'd28;
      default: d = 5'd30;
    endcase
    return d;
  endfunction

  function automatic logic [11:0] wrap_up(input logic [11:0] v, input logic [11:0] lo,
                                          input logic [11:0] hi);
    logic [12:0] n;
    n = {1'b0, v} + 13'd1;
    return (n > {1'b0, hi}) ? lo : n[11:0];
  endfunction

  function automatic logic [11:0] wrap_down(input logic [11:0] v, input logic [11:0] lo,
                                            input logic [11:0] hi);
    return (v <= lo) ? hi : v - 12'd1;
  endfunction

endpackage

// ===== hdl/cfa_update.sv =====
// Next-state logic of the calendar field adjuster: applies one command to
// the stored calendar fields. Depends on cfa_pkg.
module cfa_update (
  input  cfa_pkg::cfa_cal_t cal,
  input  cfa_pkg::cfa_in_t  item,
  output cfa_pkg::cfa_cal_t cal_next
);
  import cfa_pkg::*;

  logic [11:0] cur;
  logic [11:0] lo;
  logic [11:0] hi;
  logic [11:0] adj;
  logic        hit;

  // Pick the selected field, widened to 12 bits, with its limits.
  always_comb begin
    cur = 12'd0;
    lo  = 12'd0;
    hi  = 12'd0;
    hit = 1'b1;
    case (item.field_select)
      FLD_YEAR: begin
        cur = cal.year;
        hi  = YEAR_MAX;
      end
      FLD_MONTH: begin
        cur = {8'd0, cal.month};
        hi  = MONTH_MAX;
      end
      FLD_DAY: begin
        cur = {7'd0, cal.day_of_month};
        lo  = 12'd1;
        hi  = {7'd0, month_days(cal.month, cal.year)};
      end
      FLD_WEEKDAY: begin
        cur = {9'd0, cal.weekday};
        hi  = WEEKDAY_MAX;
      end
      FLD_HOUR: begin
        cur = {7'd0, cal.hour};
        hi  = HOUR_MAX;
      end
      FLD_MINUTE: begin
        cur = {6'd0, cal.minute};
        hi  = MINUTE_MAX;
      end
      FLD_SECOND: begin
        cur = {6'd0, cal.second};
        hi  = SECOND_MAX;
      end
      default: begin
        hit = 1'b0;
      end
    endcase
  end

  assign adj = (item.cmd == CMD_INC) ? wrap_up(cur, lo, hi) : wrap_down(cur, lo, hi);

  always_comb begin
    cal_next = cal;
    case (item.cmd)
      CMD_WRITE: begin
        cal_next.second       = item.new_second;
        cal_next.minute       = item.new_minute;
        cal_next.hour         = item.new_hour;
        cal_next.day_of_month = item.new_day_of_month;
        cal_next.weekday      = item.new_weekday;
        cal_next.day_of_year  = item.new_day_of_year;
        cal_next.month        = item.new_month;
        cal_next.year         = item.new_year;
      end
      CMD_INC, CMD_DEC: begin
        if (hit) begin
          case (item.field_select)
            FLD_YEAR:    cal_next.year         = adj;
            FLD_MONTH:   cal_next.month        = adj[3:0];
            FLD_DAY:     cal_next.day_of_month = adj[4:0];
            FLD_WEEKDAY: cal_next.weekday      = adj[2:0];
            FLD_HOUR:    cal_next.hour         = adj[4:0];
            FLD_MINUTE:  cal_next.minute       = adj[5:0];
            FLD_SECOND:  cal_next.second       = adj[5:0];
            default:     cal_next = cal;
          endcase
        end
      end
      default: begin
        cal_next = cal;
      end
    endcase
  end

endmodule

// ===== hdl/calendar_field_adjuster.sv =====
// Calendar field adjuster top level: input register, calendar state that
// doubles as the result register, and the handshake. Depends on cfa_pkg,
// cfa_update and assert_macros.svh.

// Holds the calendar fields of a real-time clock and answers every command
// transaction with one result transaction carrying all fields after the
// command. Throughput is one transaction per clock while the result is not
// stalled. A command is held in the input register; the update then lands
// in the calendar registers, which are also the result register, and
// result_valid rises with it. A stalled result holds the input register,
// and a further command is then stalled. The calendar registers only
// change when a result moves into them, so a held result never changes
// under a stall.
`include "assert_macros.svh"

module calendar_field_adjuster (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  cfa_pkg::cfa_in_t  item,
  output logic              result_valid,
  input  logic              result_stall,
  output cfa_pkg::cfa_out_t result
);
  import cfa_pkg::*;

  // Input register.
  logic      iv;
  cfa_in_t   ir;

  // Calendar state, which is also the pending result.
  logic      ov;
  cfa_cal_t  cal;
  cfa_cal_t  cal_next;

  logic      adv;
  logic      accept;
  logic      adv_read;

  // The input register drains into the state whenever the result slot is
  // empty or its transaction is being taken this cycle.
  assign adv        = iv && (!ov || !result_stall);
  assign item_stall = iv && !adv;
  assign accept     = item_valid && !item_stall;
  assign adv_read   = adv && (ir.cmd == CMD_READ);

  cfa_update u_update (
    .cal      (cal),
    .item     (ir),
    .cal_next (cal_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (accept) begin
      iv <= 1'b1;
    end else if (adv) begin
      iv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ir <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov                <= 1'b0;
      cal.second        <= 6'd0;
      cal.minute        <= 6'd0;
      cal.hour          <= 5'd0;
      cal.day_of_month  <= 5'd1;
      cal.weekday       <= 3'd0;
      cal.day_of_year   <= 9'd1;
      cal.month         <= 4'd0;
      cal.year          <= 12'd0;
    end else begin
      ov <= adv || (ov && result_stall);
      if (adv) begin
        cal <= cal_next;
      end
    end
  end

  assign result_valid            = ov;
  assign result.second_out       = cal.second;
  assign result.minute_out       = cal.minute;
  assign result.hour_out         = cal.hour;
  assign result.day_of_month_out = cal.day_of_month;
  assign result.weekday_out      = cal.weekday;
  assign result.day_of_year_out  = cal.day_of_year;
  assign result.month_out        = cal.month;
  assign result.year_out         = cal.year;

  // Stall only while a transaction sits in the input register.
  `CFA_ASSERT(a_stall_needs_item, clk, rst, !item_stall || iv, "stall with empty input register")
  // State moves only together with a result.
  `CFA_ASSERT_NEXT(a_state_only_on_adv, clk, rst, !adv, $stable(cal), "cal changed while idle")
  // A read leaves the calendar untouched and yields a result.
  `CFA_ASSERT_NEXT(a_read_keeps_state, clk, rst, adv_read, $stable(cal) && ov, "read moved state")

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for calendar_field_adjuster: a directed table, then
// random command traffic under three sender/receiver idle mixes.
// Depends on cfa_pkg and the calendar_field_adjuster RTL; reads no files.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cfa_pkg::*;

  localparam int RESET_CYCLES   = 12;
  localparam int ITEMS_PER_MIX  = 270;
  localparam int HOLD_CYCLES    = 64;    // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 1000;  // cycles with no transaction on either side
  localparam int TAIL_CYCLES    = 8;     // idle clocks after the last result

  // One directed stimulus row; the expected calendar is typed in only where
  // it is obvious, otherwise the predictor supplies it.
  typedef struct {
    cfa_in_t  cmd_in;
    bit       typed;
    cfa_out_t value;
  } directed_row_t;

  // Travels with each command from the sender to the acceptance monitor.
  typedef struct {
    bit       typed;
    cfa_out_t value;
  } typed_tag_t;

  logic     clk = 1'b0;
  logic     rst;
  logic     item_valid;
  logic     item_stall;
  cfa_in_t  item;
  logic     result_valid;
  logic     result_stall;
  cfa_out_t result;

  cfa_out_t      cal_model;          // predictor's copy of the calendar registers
  cfa_out_t      expected_cal_q[$];  // calendars still owed by the block
  typed_tag_t    typed_tag_q[$];     // one tag per command offered, in order
  directed_row_t directed_rows[$];

  int send_idle_pct;
  int recv_idle_pct;
  bit hold_req;
  int stall_run;
  int items_sent;
  int results_checked;
  int mismatch_count;
  int quiet_cycles;

  calendar_field_adjuster u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic cfa_in_t cmd_of(input logic [1:0] cmd, input logic [2:0] sel,
                                     input int s, input int mi, input int h, input int d,
                                     input int w, input int doy, input int mo, input int y);
    cfa_in_t c;
    c.cmd              = cmd;
    c.field_select     = sel;
    c.new_second       = s[5:0];
    c.new_minute       = mi[5:0];
    c.new_hour         = h[4:0];
    c.new_day_of_month = d[4:0];
    c.new_weekday      = w[2:0];
    c.new_day_of_year  = doy[8:0];
    c.new_month        = mo[3:0];
    c.new_year         = y[11:0];
    return c;
  endfunction

  function automatic cfa_out_t cal_of(input int s, input int mi, input int h, input int d,
                                      input int w, input int doy, input int mo, input int y);
    cfa_out_t r;
    r.second_out       = s[5:0];
    r.minute_out       = mi[5:0];
    r.hour_out         = h[4:0];
    r.day_of_month_out = d[4:0];
    r.weekday_out      = w[2:0];
    r.day_of_year_out  = doy[8:0];
    r.month_out        = mo[3:0];
    r.year_out         = y[11:0];
    return r;
  endfunction

  // Applies one command to the model calendar and returns the calendar after it.
  task automatic predict_calendar(input cfa_in_t c, output cfa_out_t r);
    int lo;
    int hi;
    int v;
    int m;
    int y;
    lo = 0;
    hi = 0;
    v  = 0;
    m  = cal_model.month_out;
    y  = cal_model.year_out;
    case (c.cmd)
      CMD_WRITE: begin
        // out-of-range values are kept as given (already masked by the widths)
        cal_model = cal_of(c.new_second, c.new_minute, c.new_hour, c.new_day_of_month,
                           c.new_weekday, c.new_day_of_year, c.new_month, c.new_year);
      end
      CMD_INC, CMD_DEC: begin
        case (c.field_select)
          FLD_YEAR: begin
            v  = cal_model.year_out;
            hi = YEAR_MAX;
          end
          FLD_MONTH: begin
            v  = cal_model.month_out;
            hi = MONTH_MAX;
          end
          FLD_DAY: begin
            v  = cal_model.day_of_month_out;
            lo = 1;
            case (m)
              1: begin
                hi = (((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0) ? 29 : 28;
              end
              3, 5, 8, 10: hi = 30;
              0, 2, 4, 6, 7, 9, 11: hi = 31;
              default: hi = 30;  // month codes 12..15
            endcase
          end
          FLD_WEEKDAY: begin
            v  = cal_model.weekday_out;
            hi = WEEKDAY_MAX;
          end
          FLD_HOUR: begin
            v  = cal_model.hour_out;
            hi = HOUR_MAX;
          end
          FLD_MINUTE: begin
            v  = cal_model.minute_out;
            hi = MINUTE_MAX;
          end
          FLD_SECOND: begin
            v  = cal_model.second_out;
            hi = SECOND_MAX;
          end
          default: ;
        endcase
        if (c.field_select != FLD_NONE) begin
          // above-max values wrap on increment but only step down on decrement
          if (c.cmd == CMD_INC) v = (v + 1 > hi) ? lo : v + 1;
          else                  v = (v <= lo) ? hi : v - 1;
          case (c.field_select)
            FLD_YEAR:    cal_model.year_out         = v[11:0];
            FLD_MONTH:   cal_model.month_out        = v[3:0];
            FLD_DAY:     cal_model.day_of_month_out = v[4:0];
            FLD_WEEKDAY: cal_model.weekday_out      = v[2:0];
            FLD_HOUR:    cal_model.hour_out         = v[4:0];
            FLD_MINUTE:  cal_model.minute_out       = v[5:0];
            FLD_SECOND:  cal_model.second_out       = v[5:0];
            default: ;
          endcase
        end
      end
      default: ;  // read leaves everything alone
    endcase
    r = cal_model;
  endtask

  task automatic compare_fields(input cfa_out_t e, input cfa_out_t a);
    string names[8];
    int    ev[8];
    int    av[8];
    names = '{"second", "minute", "hour", "day_of_month", "weekday", "day_of_year",
              "month", "year"};
    ev = '{e.second_out, e.minute_out, e.hour_out, e.day_of_month_out, e.weekday_out,
           e.day_of_year_out, e.month_out, e.year_out};
    av = '{a.second_out, a.minute_out, a.hour_out, a.day_of_month_out, a.weekday_out,
           a.day_of_year_out, a.month_out, a.year_out};
    for (int k = 0; k < 8; k++) begin
      if (ev[k] != av[k]) begin
        $display("t=%0t result %0d field %s: expected %0d, actual %0d",
                 $time, results_checked, names[k], ev[k], av[k]);
        mismatch_count++;
      end
    end
  endtask

  // Offers one command transaction and returns at the edge that accepts it.
  // Valid is only lowered when an idle gap is actually taken.
  task automatic send_command(input cfa_in_t c, input bit typed, input cfa_out_t value);
    typed_tag_t tag;
    tag.typed = typed;
    tag.value = value;
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    typed_tag_q.push_back(tag);
    item       <= c;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_for_drain();
    item_valid <= 1'b0;
    while (results_checked < items_sent) @(posedge clk);
  endtask

  // Receiver: random stall per cycle, or a counted hold-off when requested.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      stall_run = HOLD_CYCLES;
    end
    if (rst) begin
      result_stall <= 1'b0;
    end else if (stall_run > 0) begin
      stall_run--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Acceptance monitor: checks results, predicts on accepted commands, and
  // runs the watchdog. Results are handled before the command of the same edge.
  always @(posedge clk) begin : monitor
    typed_tag_t tag;
    cfa_out_t   predicted;
    if (!rst) begin
      quiet_cycles++;
      if (result_valid && !result_stall) begin
        quiet_cycles = 0;
        if (expected_cal_q.size() == 0) begin
          $display("t=%0t unexpected result: expected none, actual %h", $time, result);
          mismatch_count++;
        end else begin
          compare_fields(expected_cal_q.pop_front(), result);
        end
        results_checked++;
      end
      if (item_valid && !item_stall) begin
        quiet_cycles = 0;
        tag = typed_tag_q.pop_front();
        predict_calendar(item, predicted);
        expected_cal_q.push_back(tag.typed ? tag.value : predicted);
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("t=%0t watchdog: no transaction for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, expected_cal_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [63:0] raw;
    cfa_in_t     c;
    cfa_out_t    blank;
    int          pick;
    blank           = '0;
    rst             <= 1'b1;
    item_valid      <= 1'b0;
    item            <= '0;
    hold_req        = 1'b0;
    stall_run       = 0;
    items_sent      = 0;
    results_checked = 0;
    mismatch_count  = 0;
    quiet_cycles    = 0;
    send_idle_pct   = 18;
    recv_idle_pct   = 77;
    cal_model       = cal_of(0, 0, 0, 1, 0, 1, 0, 0);

    // Directed: reset values, year, month and second wrapped at both ends, the
    // rest at the low end, selector none, out-of-range writes, leap rules
    // (2000 leap, 1900 not), July length and day of month zero.
    directed_rows.push_back('{cmd_of(CMD_READ, FLD_NONE, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                              cal_of(0, 0, 0, 1, 0, 1, 0, 0)});
    directed_rows.push_back('{cmd_of(CMD_DEC, FLD_YEAR, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                              cal_of(0, 0, 0, 1, 0, 1, 0, 4095)});
    directed_rows.push_back('{cmd_of(CMD_INC, FLD_YEAR, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                              cal_of(0, 0, 0, 1, 0, 1, 0, 0)});
    directed_rows.push_back('{cmd_of(CMD_DEC, FLD_MONTH, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                              cal_of(0, 0, 0, 1, 0, 1, 11, 0)});
    directed_rows.push_back('{cmd_of(CMD_INC, FLD_MONTH, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                              cal_of(0, 0, 0, 1, 0, 1, 0, 0)});
    directed_rows.push_back('{cmd_of(CMD_DEC, FLD_SECOND, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                              cal_of(59, 0, 0, 1, 0, 1, 0, 0)});
    directed_rows.push_back('{cmd_of(CMD_DEC, FLD_MINUTE, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                              cal_of(59, 59, 0, 1, 0, 1, 0, 0)});
    directed_rows.push_back('{cmd_of(CMD_DEC, FLD_HOUR, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                              cal_of(59, 59, 23, 1, 0, 1, 0, 0)});
    directed_rows.push_back('{cmd_of(CMD_DEC, FLD_WEEKDAY, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                              cal_of(59, 59, 23, 1, 6, 1, 0, 0)});
    directed_rows.push_back('{cmd_of(CMD_DEC, FLD_DAY, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                              cal_of(59, 59, 23, 31, 6, 1, 0, 0)});
    directed_rows.push_back('{cmd_of(CMD_INC, FLD_SECOND, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                              cal_of(0, 59, 23, 31, 6, 1, 0, 0)});
    directed_rows.push_back('{cmd_of(CMD_INC, FLD_NONE, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, blank});
    directed_rows.push_back('{cmd_of(CMD_DEC, FLD_NONE, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, blank});
    // all-ones write is stored as is
    directed_rows.push_back('{cmd_of(CMD_WRITE, FLD_NONE, 63, 63, 31, 31, 7, 511, 15, 4095),
                              1'b1, cal_of(63, 63, 31, 31, 7, 511, 15, 4095)});
    directed_rows.push_back('{cmd_of(CMD_INC, FLD_SECOND, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, blank});
    directed_rows.push_back('{cmd_of(CMD_DEC, FLD_MINUTE, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, blank});
    directed_rows.push_back('{cmd_of(CMD_INC, FLD_DAY, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, blank});
    directed_rows.push_back('{cmd_of(CMD_DEC, FLD_WEEKDAY, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, blank});
    directed_rows.push_back('{cmd_of(CMD_INC, FLD_MONTH, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, blank});
    directed_rows.push_back('{cmd_of(CMD_WRITE, FLD_NONE, 0, 0, 0, 28, 0, 59, 1, 2000), 1'b0,
                              blank});
    directed_rows.push_back('{cmd_of(CMD_INC, FLD_DAY, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, blank});
    directed_rows.push_back('{cmd_of(CMD_INC, FLD_DAY, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, blank});
    directed_rows.push_back('{cmd_of(CMD_WRITE, FLD_NONE, 0, 0, 0, 28, 0, 59, 1, 1900), 1'b0,
                              blank});
    directed_rows.push_back('{cmd_of(CMD_INC, FLD_DAY, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, blank});
    directed_rows.push_back('{cmd_of(CMD_WRITE, FLD_NONE, 0, 0, 0, 0, 0, 0, 6, 0), 1'b0, blank});
    directed_rows.push_back('{cmd_of(CMD_DEC, FLD_DAY, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, blank});
    directed_rows.push_back('{cmd_of(CMD_WRITE, FLD_NONE, 0, 0, 0, 0, 0, 0, 6, 0), 1'b0, blank});
    directed_rows.push_back('{cmd_of(CMD_INC, FLD_DAY, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, blank});

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k])
      send_command(directed_rows[k].cmd_in, directed_rows[k].typed, directed_rows[k].value);

    // Random traffic: mix 0 slow receiver, mix 1 slow sender, mix 2 no idling.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 77 : 0;
      recv_idle_pct = (phase == 0) ? 77 : (phase == 1) ? 18 : 0;
      for (int i = 0; i < ITEMS_PER_MIX; i++) begin
        // receiver holds off while the sender keeps offering: the block fills up
        if (phase == 2 && i == 40) hold_req = 1'b1;
        // sender pauses until every outstanding result is back
        if (phase == 1 && i == ITEMS_PER_MIX / 2) wait_for_drain();

        raw = {$urandom(), $urandom()};
        c   = raw[$bits(cfa_in_t)-1:0];
        pick = $urandom_range(99);
        if (pick < 15)      c.cmd = CMD_WRITE;
        else if (pick < 25) c.cmd = CMD_READ;
        else if (pick < 62) c.cmd = CMD_INC;
        else                c.cmd = CMD_DEC;
        if ($urandom_range(3) == 0) c.field_select = FLD_DAY;

        // Most writes land in range near the wrap points; the rest keep raw bits.
        if (c.cmd == CMD_WRITE && $urandom_range(4) != 0) begin
          c.new_second = ($urandom_range(1)) ? 6'd59 : 6'($urandom_range(59));
          c.new_minute = ($urandom_range(1)) ? 6'd59 : 6'($urandom_range(59));
          c.new_hour   = ($urandom_range(1)) ? 5'd23 : 5'($urandom_range(23));
          c.new_weekday = 3'($urandom_range(6));
          c.new_day_of_year = 9'($urandom_range(366, 1));
          c.new_day_of_month = ($urandom_range(1)) ? 5'($urandom_range(31, 27))
                                                   : 5'($urandom_range(31, 1));
          c.new_month = ($urandom_range(2) == 0) ? 4'd1 : 4'($urandom_range(11));
          case ($urandom_range(3))
            0: c.new_year = 12'($urandom_range(40) * 100);
            1: c.new_year = 12'($urandom_range(10) * 400);
            2: c.new_year = 12'($urandom_range(1023) * 4);
            default: c.new_year = 12'($urandom_range(4095));
          endcase
        end
        send_command(c, 1'b0, blank);
      end
    end

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d directed and %0d random commands over three idle mixes;",
             directed_rows.size(), items_sent - directed_rows.size());
    $display("%0d results compared field by field, %0d field mismatches.",
             results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
